// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    localparam int OPERAND_BITS = 32;                 // operand field width
    localparam int VAL_BITS     = OPERAND_BITS - 1;   // magnitude of a valid operand
    localparam int RES_BITS     = 31;                 // power_mod field width
    localparam int CNT_BITS     = $clog2(VAL_BITS);   // multiplier bit counter

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VAL_BITS - 1);

    typedef logic [VAL_BITS-1:0] t_val;

    // One modular multiplication request: prod = (a * b) mod n, a <= n
    typedef struct packed {
        logic start;
        t_val a;
        t_val b;
        t_val n;
    } t_mul_req;

endpackage

`default_nettype wire

// ===== rtl/mexp_if.sv =====
// ----------------------------------------------------------------------------
// mexp_if
// Valid/ready channels of the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [mexp_pkg::OPERAND_BITS-1:0] base;
    logic signed [mexp_pkg::OPERAND_BITS-1:0] exponent;
    logic signed [mexp_pkg::OPERAND_BITS-1:0] modulus;

    modport source (output valid, output base, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base, input exponent, input modulus,
                    output ready);
endinterface

interface mexp_out_if;
    logic                              valid;
    logic                              ready;
    logic [mexp_pkg::RES_BITS-1:0]     power_mod;
    logic                              bad_operand;

    modport source (output valid, output power_mod, output bad_operand, input ready);
    modport sink   (input valid, input power_mod, input bad_operand, output ready);
endinterface

`default_nettype wire

// ===== rtl/mexp_modmul.sv =====
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial modular multiplier: one bit of b per cycle, MSB first,
// r <- (2r + b_i*a) mod n with a two-level conditional subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_modmul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mexp_pkg::t_mul_req i_req,
    output logic                    o_done,
    output mexp_pkg::t_val          o_prod
);
    import mexp_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    t_val                r_a;
    t_val                r_b;
    t_val                r_n;
    t_val                r_r;

    logic [VAL_BITS+1:0] w_t;
    logic [VAL_BITS+1:0] w_n1;
    logic [VAL_BITS+1:0] w_n2;
    t_val                n_r;

    // 2r + a < 3n, so at most 2n comes off
    always_comb begin
        w_n1 = {2'b00, r_n};
        w_n2 = {1'b0, r_n, 1'b0};
        w_t  = {1'b0, r_r, 1'b0} + (r_b[VAL_BITS-1] ? {2'b00, r_a} : '0);
        if (w_t >= w_n2) begin
            n_r = VAL_BITS'(w_t - w_n2);
        end else if (w_t >= w_n1) begin
            n_r = VAL_BITS'(w_t - w_n1);
        end else begin
            n_r = VAL_BITS'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_LAST;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_n    <= i_req.n;
                r_r    <= '0;
            end else if (r_busy) begin
                r_r <= n_r;
                r_b <= {r_b[VAL_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_r;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiply started while busy");

    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_r < r_n))
        else $error("product not reduced below modulus");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");

endmodule

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square and multiply on one
// shared bit-serial modular multiplier. Invalid operands give 0 and a flag.
//
//   channel  dir  words                                  handshake
//   i_in     in   base, exponent, modulus (32b signed)   valid/ready
//   o_out    out  power_mod (31b), bad_operand (1b)      valid/ready
//
// The multiplier is bit-serial, one multiplier bit per cycle. An item costs
// 2 multiplications of setup, then per exponent bit up to the MSB a test,
// a multiply where the bit is set and a squaring, then a final test and the
// output load. Invalid operands go straight from input to the output load.
// Input is taken again once the result sits in the output register, even
// if the sink stalls it there.
// Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mexp_in_if.sink    i_in,
    mexp_out_if.source o_out
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC0,
        S_SQ0,
        S_TEST,
        S_MACC,
        S_MSQ,
        S_FINISH
    } t_state;

    t_state              r_state;
    t_mul_req            r_req;
    t_val                r_b;
    t_val                r_n;
    t_val                r_e;
    t_val                r_acc;
    t_val                r_sq;
    logic [RES_BITS-1:0] r_res;
    logic                r_bad;
    logic                r_out_valid;
    logic [RES_BITS-1:0] r_out_pm;
    logic                r_out_bad;

    logic                w_done;
    t_val                w_prod;
    logic                w_bad;
    logic                w_in_acc;
    t_val                w_one;

    assign w_one = VAL_BITS'(1);

    assign w_bad = i_in.base[OPERAND_BITS-1] || (i_in.base == '0) ||
                   i_in.exponent[OPERAND_BITS-1] ||
                   i_in.modulus[OPERAND_BITS-1] || (i_in.modulus == '0);

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && (r_state == S_IDLE);

    mexp_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_bad) begin
                            r_res   <= '0;
                            r_bad   <= 1'b1;
                            r_state <= S_FINISH;
                        end else begin
                            r_b         <= i_in.base[VAL_BITS-1:0];
                            r_n         <= i_in.modulus[VAL_BITS-1:0];
                            r_e         <= i_in.exponent[VAL_BITS-1:0];
                            // acc = 1 mod n
                            r_req.start <= 1'b1;
                            r_req.a     <= w_one;
                            r_req.b     <= w_one;
                            r_req.n     <= i_in.modulus[VAL_BITS-1:0];
                            r_state     <= S_ACC0;
                        end
                    end
                end
                S_ACC0: begin
                    if (w_done) begin
                        // sq = b mod n, as 1 * b reduced bit by bit
                        r_acc       <= w_prod;
                        r_req.start <= 1'b1;
                        r_req.a     <= w_one;
                        r_req.b     <= r_b;
                        r_req.n     <= r_n;
                        r_state     <= S_SQ0;
                    end
                end
                S_SQ0: begin
                    if (w_done) begin
                        r_sq    <= w_prod;
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (r_e == '0) begin
                        r_res   <= RES_BITS'(r_acc);
                        r_bad   <= 1'b0;
                        r_state <= S_FINISH;
                    end else if (r_e[0]) begin
                        r_req.start <= 1'b1;
                        r_req.a     <= r_acc;
                        r_req.b     <= r_sq;
                        r_req.n     <= r_n;
                        r_state     <= S_MACC;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.a     <= r_sq;
                        r_req.b     <= r_sq;
                        r_req.n     <= r_n;
                        r_state     <= S_MSQ;
                    end
                end
                S_MACC: begin
                    if (w_done) begin
                        r_acc       <= w_prod;
                        r_req.start <= 1'b1;
                        r_req.a     <= r_sq;
                        r_req.b     <= r_sq;
                        r_req.n     <= r_n;
                        r_state     <= S_MSQ;
                    end
                end
                S_MSQ: begin
                    if (w_done) begin
                        r_sq    <= w_prod;
                        r_e     <= {1'b0, r_e[VAL_BITS-1:1]};
                        r_state <= S_TEST;
                    end
                end
                S_FINISH: begin
                    // output register free or emptied this cycle
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pm    <= r_res;
                        r_out_bad   <= r_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.power_mod   = r_out_pm;
    assign o_out.bad_operand = r_out_bad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_pm == '0))
        else $error("invalid operands gave a nonzero word");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST) |-> ((r_acc < r_n) && (r_sq < r_n)))
        else $error("accumulator or square not below modulus");

    a_mul_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_ACC0 || r_state == S_SQ0 ||
                    r_state == S_MACC || r_state == S_MSQ))
        else $error("multiplier finished outside a multiply state");

endmodule

`default_nettype wire

// ===== sim/tb_modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Drives operand words into the modular exponentiation block and checks
// every result word against a square-and-multiply predictor in the bench.
// A directed set covers extremes, invalid operands, zero exponent, base
// above modulus and modulus one; random words follow, with random gaps on
// both channels and one stretch with no gaps at all.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    localparam int RANDOM_WORDS = 270;
    localparam int HANG_LIMIT   = 20000;   // cycles with no word moved
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic signed [OPERAND_BITS-1:0] base;
        logic signed [OPERAND_BITS-1:0] exponent;
        logic signed [OPERAND_BITS-1:0] modulus;
    } operands_t;

    typedef struct packed {
        logic [RES_BITS-1:0] power_mod;
        logic                bad_operand;
    } powmod_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mexp_in_if  in_if ();
    mexp_out_if out_if ();

    modular_exponentiation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    operands_t operand_q[$];     // words not yet offered
    powmod_t   powmod_q[$];      // predicted results, oldest first
    int        err_cnt;
    int        taken_cnt;
    int        hang_cnt;
    logic      in_taken;
    logic      out_taken;
    logic      no_gaps;

    always #5 i_clk = ~i_clk;

    // exact (a * b) mod n, one multiplier bit per step
    function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] n);
        logic [63:0] r;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = r << 1;
            if (r >= n) r = r - n;
            if (b[i]) begin
                r = r + a;
                if (r >= n) r = r - n;
            end
        end
        return r;
    endfunction

    function automatic powmod_t powmod_predict(input operands_t op);
        powmod_t     res;
        logic [63:0] n;
        logic [63:0] e;
        logic [63:0] acc;
        logic [63:0] sq;
        res = '0;
        if ($signed(op.base) <= 0 || $signed(op.exponent) < 0 ||
            $signed(op.modulus) <= 0) begin
            res.bad_operand = 1'b1;
            return res;
        end
        n   = 64'(unsigned'(op.modulus));
        e   = 64'(unsigned'(op.exponent));
        acc = 64'd1 % n;
        sq  = 64'(unsigned'(op.base)) % n;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, sq, n);
            sq = mulmod(sq, sq, n);
            e  = e >> 1;
        end
        res.power_mod = acc[RES_BITS-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %0s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic add_word(input logic [31:0] b, input logic [31:0] e,
                            input logic [31:0] n);
        operands_t op;
        op.base     = b;
        op.exponent = e;
        op.modulus  = n;
        operand_q.push_back(op);
    endtask

    // positive value of random bit length, never zero
    function automatic logic [31:0] rand_positive();
        int          w;
        logic [31:0] v;
        w = $urandom_range(31, 1);
        v = $urandom >> (32 - w);
        if (v == 0) v = 1;
        return v;
    endfunction

    function automatic operands_t random_operands();
        operands_t op;
        if ($urandom_range(99) < 75) begin
            op.base     = rand_positive();
            op.exponent = ($urandom_range(3) == 0) ? rand_positive() - 1
                                                   : $urandom & 32'h7fff_ffff;
            op.modulus  = rand_positive();
        end else begin
            op.base     = $urandom;
            op.exponent = $urandom;
            op.modulus  = $urandom;
            case ($urandom_range(4))
                0: op.base[31]     = 1'b1;
                1: op.base         = '0;
                2: op.exponent[31] = 1'b1;
                3: op.modulus[31]  = 1'b1;
                default: op.modulus = '0;
            endcase
        end
        return op;
    endfunction

    // no gaps on either side for a stretch in the middle of the run
    assign no_gaps = (taken_cnt >= 120) && (taken_cnt < 170);

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            if (!in_if.valid || in_taken) begin
                if (operand_q.size() != 0 && (no_gaps || $urandom_range(99) >= 19)) begin
                    in_if.base     <= operand_q[0].base;
                    in_if.exponent <= operand_q[0].exponent;
                    in_if.modulus  <= operand_q[0].modulus;
                    in_if.valid    <= 1'b1;
                    void'(operand_q.pop_front());
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= no_gaps || ($urandom_range(99) >= 19);
        end
    end

    // monitor: sample both channels on the rising edge
    always @(posedge i_clk) begin
        powmod_t op_res;
        powmod_t exp_res;
        in_taken  = i_rst_n && in_if.valid && in_if.ready;
        out_taken = i_rst_n && out_if.valid && out_if.ready;
        if (in_taken) begin
            op_res = powmod_predict({in_if.base, in_if.exponent, in_if.modulus});
            powmod_q.push_back(op_res);
            taken_cnt++;
        end
        if (out_taken) begin
            if (powmod_q.size() == 0) begin
                report_mismatch($sformatf("result word with none expected: %0d/%0b",
                                          out_if.power_mod, out_if.bad_operand));
            end else begin
                exp_res = powmod_q.pop_front();
                if (out_if.power_mod !== exp_res.power_mod)
                    report_mismatch($sformatf("power_mod got %0d expected %0d",
                                              out_if.power_mod, exp_res.power_mod));
                if (out_if.bad_operand !== exp_res.bad_operand)
                    report_mismatch($sformatf("bad_operand got %0b expected %0b",
                                              out_if.bad_operand, exp_res.bad_operand));
            end
        end
    end

    // watchdog: counts cycles in which no word moves on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            hang_cnt <= 0;
        end else if (hang_cnt >= HANG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            hang_cnt <= hang_cnt + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.base      = '0;
        in_if.exponent  = '0;
        in_if.modulus   = '0;
        out_if.ready    = 1'b0;
        in_taken        = 1'b0;
        out_taken       = 1'b0;
        err_cnt         = 0;
        taken_cnt       = 0;
        hang_cnt        = 0;

        // directed: extremes and special cases
        add_word(32'd1,          32'd0,          32'd1);          // zero exponent, modulus one
        add_word(32'd5,          32'd0,          32'd7);          // zero exponent
        add_word(32'd2,          32'd10,         32'd1000);
        add_word(32'd100,        32'd3,          32'd7);          // base above modulus
        add_word(32'd12345,      32'd678,        32'd1);          // modulus one
        add_word(32'h7fff_ffff,  32'h7fff_ffff,  32'h7fff_ffff);  // base equals modulus
        add_word(32'h7fff_ffff,  32'h7fff_ffff,  32'h7fff_fffe);
        add_word(32'd2,          32'h7fff_fffe,  32'h7fff_ffff);  // Fermat, prime modulus
        add_word(32'd3,          32'h7fff_ffff,  32'h7fff_ffff);
        add_word(32'h7fff_fffe,  32'd2,          32'h7fff_ffff);  // largest square
        add_word(32'd1,          32'h7fff_ffff,  32'd2);
        add_word(32'h5555_5555,  32'h2aaa_aaaa,  32'h4000_0001);
        add_word(32'h2aaa_aaaa,  32'h5555_5555,  32'h3fff_ffff);
        add_word(32'd0,          32'd5,          32'd7);          // invalid: base zero
        add_word(32'h8000_0000,  32'd5,          32'd7);          // invalid: base most negative
        add_word(32'hffff_ffff,  32'd5,          32'd7);          // invalid: base minus one
        add_word(32'd3,          32'hffff_ffff,  32'd7);          // invalid: exponent negative
        add_word(32'd3,          32'h8000_0000,  32'd7);
        add_word(32'd3,          32'd5,          32'd0);          // invalid: modulus zero
        add_word(32'd3,          32'd5,          32'hffff_ffff);
        add_word(32'd3,          32'd5,          32'h8000_0000);
        add_word(32'hffff_ffff,  32'hffff_ffff,  32'hffff_ffff);  // all fields bad

        for (int k = 0; k < RANDOM_WORDS; k++)
            operand_q.push_back(random_operands());

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (operand_q.size() != 0 || in_if.valid || powmod_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mexp_pkg.sv
rtl/mexp_if.sv
rtl/mexp_modmul.sv
rtl/modular_exponentiation.sv
sim/tb_modular_exponentiation.sv
